// ===== design/xray_amplitude_restraint_energy_core_assert.svh =====
// assertion macros for the amplitude restraint energy core
// used by the top level only; empty bodies under SYNTHESIS
`ifndef XRAY_AMPLITUDE_RESTRAINT_ENERGY_CORE_ASSERT_SVH
`define XRAY_AMPLITUDE_RESTRAINT_ENERGY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define XARE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xare: assertion failed");
`define XARE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xare: assertion failed");
`else
`define XARE_ASSERT_SAME(lbl, ante, cons)
`define XARE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/xare_pkg.sv =====
// shared types, codes and arithmetic helpers of the amplitude restraint core
// no dependencies; imported by xare_dp, xare_ctrl and the top level
package xare_pkg;

  localparam int AMP_FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_INS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_AVG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RES   = 3'd4;

  localparam logic [1:0] MODE_INST = 2'd0;
  localparam logic [1:0] MODE_AVG  = 2'd1;
  localparam logic [1:0] MODE_BIQ  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [63:0] SAT64   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_DIV, OP_W_ONE, OP_NF_ONE,
    OP_NS_ADD, OP_ES_ADD, OP_SMADD, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    SRC_FOBS, SRC_SIGMA, SRC_SI, SRC_SA, SRC_FCI, SRC_FCA, SRC_K, SRC_FCS,
    SRC_KI, SRC_KA, SRC_KQ, SRC_FC, SRC_NF, SRC_NS, SRC_ES, SRC_W, SRC_NW,
    SRC_T, SRC_U, SRC_T2, SRC_U2, SRC_X, SRC_Y, SRC_DM
  } src_t;

  typedef enum logic [3:0] {
    DST_X, DST_Y, DST_W, DST_NW, DST_T, DST_U, DST_T2, DST_U2,
    DST_NF, DST_DM, DST_DMT, DST_EN
  } dst_t;

  typedef enum logic [2:0] {
    SH_ZERO, SH_SQ, SH_32, SH_DIFF, SH_EN, SH_WT, SH_NF
  } sh_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    sh_t  sh;
    dst_t dst;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic used;
    logic req;
    logic last;
    logic biq;
    logic sigma_zero;
    logic ns_zero;
    logic out_free;
  } stat_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? SAT64 : s[63:0];
  endfunction

  // floor(p / 2^sh) or p * 2^-sh, saturating at 64 bits
  function automatic logic [63:0] scale_out(input logic [127:0] p, input int sh);
    logic [127:0] q;
    logic [63:0]  r;
    if (sh >= 0) begin
      q = p >> sh;
      r = (q[127:64] != '0) ? SAT64 : q[63:0];
    end else begin
      q = p << (-sh);
      r = ((p >> (64 + sh)) != '0) ? SAT64 : q[63:0];
    end
    return r;
  endfunction

endpackage

// ===== design/xare_dp.sv =====
// datapath: config registers, item registers, 4-pass 32x32 multiplier,
// restoring divider, sums and result register; depends on xare_pkg
module xare_dp
  import xare_pkg::*;
#(
  parameter int AMP_FRAC_BITS = AMP_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output stat_t                st,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [175:0]         in_tdata,
  input  logic                 in_tuser,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [127:0]         out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast
);

  localparam int F        = AMP_FRAC_BITS;
  localparam int SHV_SQ   = 2 * F - 32;
  localparam int SHV_DIFF = F + 8;
  localparam int SHV_EN   = F + 1;
  localparam int FO_SH    = 32 - F;
  localparam logic [6:0]  DIV_TOP_WT = 7'(2 * F + 32);
  localparam logic [6:0]  DIV_TOP_NF = 7'd64;
  localparam logic [31:0] ONE_AMP    = 32'(1) << F;
  localparam logic [63:0] POS_LIM    = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIM    = 64'h0000_8000_0000_0000;

  logic [1:0]  mode_r;
  logic [31:0] si_r, sa_r, fc_r, maxr_r;

  logic        req_r, last_r;
  logic [31:0] fobs_r, sigma_r, fci_r, fca_r, inv_r;
  logic [15:0] phase_r;

  logic [63:0] ns_r, nf_r, es_r, w_r, nw_r, t_r, u_r, t2_r, u2_r, x_r, y_r, dm_r, en_r;
  logic        tn_r, un_r, dneg_r;

  logic [63:0]  ma_r, mb_r, pp_r, res_r;
  logic [127:0] acc_r;
  sh_t          msh_r;
  dst_t         dst_r;
  logic [2:0]   mcnt_r;
  logic [1:0]   ppk_r;
  logic         mbusy_r;

  logic [63:0] dden_r, dr_r, dq_r;
  logic [6:0]  dcnt_r;
  logic        dfirst_r, dbusy_r, dfin_r, dsat_r;

  logic         out_valid_r, out_user_r, out_last_r;
  logic [47:0]  out_diff_r;
  logic [15:0]  out_ph_r;
  logic [63:0]  out_en_r;

  logic [31:0]  ah, bh;
  logic [63:0]  prod;
  logic [127:0] ppx;
  logic [63:0]  scaled;
  logic [64:0]  dr65, ddiff;
  logic         dge;
  logic         wr_en;
  logic [63:0]  wr_val, fo, tmag;
  logic         tneg;
  logic [63:0]  sm_mag, clamp_mag;
  logic         sm_neg, used;
  logic [47:0]  diff_val;

  function automatic logic [63:0] src_val(input src_t s);
    case (s)
      SRC_FOBS:  return 64'(fobs_r);
      SRC_SIGMA: return 64'(sigma_r);
      SRC_SI:    return 64'(si_r);
      SRC_SA:    return 64'(sa_r);
      SRC_FCI:   return 64'(fci_r);
      SRC_FCA:   return 64'(fca_r);
      SRC_K:     return 64'((mode_r == MODE_INST) ? si_r : sa_r);
      SRC_FCS:   return 64'((mode_r == MODE_INST) ? fci_r : fca_r);
      SRC_KI:    return 64'(si_r) << FO_SH;
      SRC_KA:    return 64'(sa_r) << FO_SH;
      SRC_KQ:    return 64'((mode_r == MODE_INST) ? si_r : sa_r) << FO_SH;
      SRC_FC:    return 64'(fc_r);
      SRC_NF:    return nf_r;
      SRC_NS:    return ns_r;
      SRC_ES:    return es_r;
      SRC_W:     return w_r;
      SRC_NW:    return nw_r;
      SRC_T:     return t_r;
      SRC_U:     return u_r;
      SRC_T2:    return t2_r;
      SRC_U2:    return u2_r;
      SRC_Y:     return y_r;
      SRC_DM:    return dm_r;
      default:   return x_r;
    endcase
  endfunction

  // one 32x32 partial product per pass, low halves first
  always_comb begin
    ah   = mcnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    bh   = mcnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    prod = ah * bh;
    case (ppk_r)
      2'd0:    ppx = {64'b0, pp_r};
      2'd1:    ppx = {32'b0, pp_r, 32'b0};
      default: ppx = {pp_r, 64'b0};
    endcase
    case (msh_r)
      SH_ZERO: scaled = scale_out(acc_r, 0);
      SH_SQ:   scaled = scale_out(acc_r, SHV_SQ);
      SH_DIFF: scaled = scale_out(acc_r, SHV_DIFF);
      SH_EN:   scaled = scale_out(acc_r, SHV_EN);
      default: scaled = scale_out(acc_r, 32);
    endcase
  end

  always_comb begin
    dr65  = {dr_r, dfirst_r};
    dge   = dr65 >= {1'b0, dden_r};
    ddiff = dr65 - {1'b0, dden_r};
  end

  always_comb begin
    wr_en  = (mbusy_r && mcnt_r == 3'd6) || dfin_r;
    wr_val = dfin_r ? (dsat_r ? SAT64 : dq_r) : res_r;
    fo     = 64'(fobs_r) << FO_SH;
    tneg   = wr_val > fo;
    tmag   = tneg ? wr_val - fo : fo - wr_val;
  end

  // signed-magnitude sum of the two biquadratic derivative parts
  always_comb begin
    if (tn_r == un_r) begin
      sm_mag = sat_add(x_r, y_r);
      sm_neg = tn_r;
    end else if (x_r >= y_r) begin
      sm_mag = x_r - y_r;
      sm_neg = tn_r;
    end else begin
      sm_mag = y_r - x_r;
      sm_neg = un_r;
    end
  end

  always_comb begin
    used = (inv_r <= maxr_r) && !(req_r && mode_r == MODE_NONE);
    if (dneg_r) begin
      clamp_mag = (dm_r > NEG_LIM) ? NEG_LIM : dm_r;
      diff_val  = 48'(64'd0 - clamp_mag);
    end else begin
      clamp_mag = (dm_r > POS_LIM) ? POS_LIM : dm_r;
      diff_val  = clamp_mag[47:0];
    end
  end

  always_comb begin
    st.done       = wr_en;
    st.used       = used;
    st.req        = req_r;
    st.last       = last_r;
    st.biq        = (mode_r == MODE_BIQ);
    st.sigma_zero = (sigma_r == '0);
    st.ns_zero    = (ns_r == '0);
    st.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_INST;
      si_r        <= ONE_AMP;
      sa_r        <= ONE_AMP;
      fc_r        <= ONE_AMP;
      maxr_r      <= '1;
      ns_r        <= '0;
      nf_r        <= ONE_Q32;
      es_r        <= '0;
      mbusy_r     <= 1'b0;
      mcnt_r      <= '0;
      dbusy_r     <= 1'b0;
      dfin_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MODE:      mode_r <= cfg_data[1:0];
          REG_SCALE_INS: si_r   <= cfg_data;
          REG_SCALE_AVG: sa_r   <= cfg_data;
          REG_FORCE:     fc_r   <= cfg_data;
          REG_MAX_RES:   maxr_r <= cfg_data;
          default: ;
        endcase
      end

      // multiplier passes
      if (mbusy_r) begin
        if (mcnt_r <= 3'd3) begin
          pp_r  <= prod;
          ppk_r <= 2'(mcnt_r[0]) + 2'(mcnt_r[1]);
        end
        if (mcnt_r >= 3'd1 && mcnt_r <= 3'd4) acc_r <= acc_r + ppx;
        if (mcnt_r == 3'd5) res_r <= scaled;
        if (mcnt_r == 3'd6) mbusy_r <= 1'b0;
        mcnt_r <= mcnt_r + 3'd1;
      end

      // divider, one quotient bit a cycle
      if (dfin_r) begin
        dfin_r  <= 1'b0;
        dbusy_r <= 1'b0;
      end else if (dbusy_r) begin
        dr_r     <= dge ? ddiff[63:0] : dr65[63:0];
        dq_r     <= {dq_r[62:0], dge};
        dfirst_r <= 1'b0;
        if (dge && dcnt_r >= 7'd64) dsat_r <= 1'b1;
        if (dcnt_r == '0) dfin_r <= 1'b1;
        else dcnt_r <= dcnt_r - 7'd1;
      end

      if (wr_en) begin
        case (dst_r)
          DST_X:   x_r  <= wr_val;
          DST_Y:   y_r  <= wr_val;
          DST_W:   w_r  <= wr_val;
          DST_NW:  nw_r <= wr_val;
          DST_T: begin
            t_r  <= tmag;
            tn_r <= tneg;
          end
          DST_U: begin
            u_r  <= tmag;
            un_r <= tneg;
          end
          DST_T2:  t2_r <= wr_val;
          DST_U2:  u2_r <= wr_val;
          DST_NF: begin
            nf_r <= wr_val;
            ns_r <= '0;
          end
          DST_DM:  dm_r <= wr_val;
          DST_DMT: begin
            dm_r   <= wr_val;
            dneg_r <= !tn_r;
          end
          default: begin
            en_r <= wr_val;
            es_r <= '0;
          end
        endcase
      end

      if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      case (cmd.op)
        OP_LOAD: begin
          req_r   <= in_tuser;
          last_r  <= in_tlast;
          fobs_r  <= in_tdata[31:0];
          sigma_r <= in_tdata[63:32];
          fci_r   <= in_tdata[95:64];
          fca_r   <= in_tdata[127:96];
          phase_r <= in_tdata[143:128];
          inv_r   <= in_tdata[175:144];
        end
        OP_MUL: begin
          ma_r    <= src_val(cmd.a);
          mb_r    <= src_val(cmd.b);
          msh_r   <= cmd.sh;
          dst_r   <= cmd.dst;
          acc_r   <= '0;
          mcnt_r  <= '0;
          mbusy_r <= 1'b1;
        end
        OP_DIV: begin
          dden_r   <= src_val(cmd.b);
          dcnt_r   <= (cmd.sh == SH_NF) ? DIV_TOP_NF : DIV_TOP_WT;
          dst_r    <= cmd.dst;
          dr_r     <= '0;
          dq_r     <= '0;
          dsat_r   <= 1'b0;
          dfirst_r <= 1'b1;
          dbusy_r  <= 1'b1;
        end
        OP_W_ONE: w_r <= ONE_Q32;
        OP_NF_ONE: begin
          nf_r <= ONE_Q32;
          ns_r <= '0;
        end
        OP_NS_ADD: ns_r <= sat_add(ns_r, y_r);
        OP_ES_ADD: es_r <= sat_add(es_r, x_r);
        OP_SMADD: begin
          dm_r   <= sm_mag;
          dneg_r <= !sm_neg;
        end
        OP_OUT: begin
          out_diff_r  <= used ? diff_val : '0;
          out_ph_r    <= used ? phase_r : '0;
          out_user_r  <= used;
          out_en_r    <= last_r ? en_r : '0;
          out_last_r  <= last_r;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_en_r, out_ph_r, out_diff_r};
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/xare_ctrl.sv =====
// sequencer: walks one reflection through the shared multiplier and divider
// issues commands to xare_dp and waits on its status; depends on xare_pkg
module xare_ctrl
  import xare_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_CHK, S_WSQ, S_WDIV, S_AF2, S_AF4, S_AWF, S_AADD, S_NSFIN, S_NFDIV,
    S_NW, S_KF, S_T2, S_E0, S_EA0, S_X, S_D,
    S_BTI, S_BTA, S_BT2, S_BU2, S_BA1, S_BA, S_BB1, S_BB, S_BS, S_BE1, S_BE,
    S_BEA, S_BD, S_F, S_EN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   issued_r;
  logic   multi, adv;

  always_comb begin
    cmd       = '{OP_NONE, SRC_X, SRC_X, SH_32, DST_X};
    state_nxt = state_r;
    multi     = 1'b0;
    adv       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        adv       = in_tvalid;
        state_nxt = S_CHK;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      S_CHK: begin
        if (!st.used) begin
          if (st.req) state_nxt = st.last ? S_EN : S_OUT;
          else state_nxt = st.last ? S_NSFIN : S_IDLE;
        end else if (st.sigma_zero) begin
          cmd.op    = OP_W_ONE;
          state_nxt = st.req ? S_NW : S_AF2;
        end else begin
          state_nxt = S_WSQ;
        end
      end
      S_WSQ: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_SIGMA; cmd.b = SRC_SIGMA; cmd.sh = SH_ZERO; cmd.dst = DST_X;
        state_nxt = S_WDIV;
      end
      S_WDIV: begin
        multi = 1'b1; cmd.op = OP_DIV;
        cmd.b = SRC_X; cmd.sh = SH_WT; cmd.dst = DST_W;
        state_nxt = st.req ? S_NW : S_AF2;
      end
      S_AF2: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_FOBS; cmd.b = SRC_FOBS; cmd.sh = SH_SQ; cmd.dst = DST_X;
        state_nxt = st.biq ? S_AF4 : S_AWF;
      end
      S_AF4: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_X; cmd.b = SRC_X; cmd.sh = SH_32; cmd.dst = DST_X;
        state_nxt = S_AWF;
      end
      S_AWF: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_W; cmd.b = SRC_X; cmd.sh = SH_32; cmd.dst = DST_Y;
        state_nxt = S_AADD;
      end
      S_AADD: begin
        cmd.op    = OP_NS_ADD;
        state_nxt = st.last ? S_NSFIN : S_IDLE;
      end
      S_NSFIN: begin
        if (st.ns_zero) begin
          cmd.op    = OP_NF_ONE;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_NFDIV;
        end
      end
      S_NFDIV: begin
        multi = 1'b1; cmd.op = OP_DIV;
        cmd.b = SRC_NS; cmd.sh = SH_NF; cmd.dst = DST_NF;
        state_nxt = S_IDLE;
      end
      S_NW: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_NF; cmd.b = SRC_W; cmd.sh = SH_32; cmd.dst = DST_NW;
        state_nxt = st.biq ? S_BTI : S_KF;
      end
      S_KF: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_K; cmd.b = SRC_FCS; cmd.sh = SH_SQ; cmd.dst = DST_T;
        state_nxt = S_T2;
      end
      S_T2: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_T; cmd.b = SRC_T; cmd.sh = SH_32; cmd.dst = DST_T2;
        state_nxt = S_E0;
      end
      S_E0: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_NW; cmd.b = SRC_T2; cmd.sh = SH_32; cmd.dst = DST_X;
        state_nxt = S_EA0;
      end
      S_EA0: begin
        cmd.op    = OP_ES_ADD;
        state_nxt = S_X;
      end
      S_X: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_NW; cmd.b = SRC_T; cmd.sh = SH_32; cmd.dst = DST_X;
        state_nxt = S_D;
      end
      S_D: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_X; cmd.b = SRC_KQ; cmd.sh = SH_32; cmd.dst = DST_DMT;
        state_nxt = S_F;
      end
      S_BTI: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_SI; cmd.b = SRC_FCI; cmd.sh = SH_SQ; cmd.dst = DST_T;
        state_nxt = S_BTA;
      end
      S_BTA: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_SA; cmd.b = SRC_FCA; cmd.sh = SH_SQ; cmd.dst = DST_U;
        state_nxt = S_BT2;
      end
      S_BT2: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_T; cmd.b = SRC_T; cmd.sh = SH_32; cmd.dst = DST_T2;
        state_nxt = S_BU2;
      end
      S_BU2: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_U; cmd.b = SRC_U; cmd.sh = SH_32; cmd.dst = DST_U2;
        state_nxt = S_BA1;
      end
      S_BA1: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_T; cmd.b = SRC_U2; cmd.sh = SH_32; cmd.dst = DST_X;
        state_nxt = S_BA;
      end
      S_BA: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_X; cmd.b = SRC_KI; cmd.sh = SH_32; cmd.dst = DST_X;
        state_nxt = S_BB1;
      end
      S_BB1: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_U; cmd.b = SRC_T2; cmd.sh = SH_32; cmd.dst = DST_Y;
        state_nxt = S_BB;
      end
      S_BB: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_Y; cmd.b = SRC_KA; cmd.sh = SH_32; cmd.dst = DST_Y;
        state_nxt = S_BS;
      end
      S_BS: begin
        cmd.op    = OP_SMADD;
        state_nxt = S_BE1;
      end
      S_BE1: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_T2; cmd.b = SRC_U2; cmd.sh = SH_32; cmd.dst = DST_X;
        state_nxt = S_BE;
      end
      S_BE: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_NW; cmd.b = SRC_X; cmd.sh = SH_32; cmd.dst = DST_X;
        state_nxt = S_BEA;
      end
      S_BEA: begin
        cmd.op    = OP_ES_ADD;
        state_nxt = S_BD;
      end
      S_BD: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_NW; cmd.b = SRC_DM; cmd.sh = SH_32; cmd.dst = DST_DM;
        state_nxt = S_F;
      end
      S_F: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_FC; cmd.b = SRC_DM; cmd.sh = SH_DIFF; cmd.dst = DST_DM;
        state_nxt = st.last ? S_EN : S_OUT;
      end
      S_EN: begin
        multi = 1'b1; cmd.op = OP_MUL;
        cmd.a = SRC_FC; cmd.b = SRC_ES; cmd.sh = SH_EN; cmd.dst = DST_EN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        adv       = st.out_free;
        state_nxt = S_IDLE;
        if (st.out_free) cmd.op = OP_OUT;
      end
      default: state_nxt = S_IDLE;
    endcase
    // a unit command goes out once, on the first cycle of its step
    if (multi && issued_r) cmd.op = OP_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
    end else if (multi) begin
      if (!issued_r) begin
        issued_r <= 1'b1;
      end else if (st.done) begin
        issued_r <= 1'b0;
        state_r  <= state_nxt;
      end
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// ===== design/xray_amplitude_restraint_energy_core.sv =====
// each 64x64 product runs on the one 32x32 multiplier; each reciprocal runs on the
// restoring divider; one beat in flight at a time
// a finished result waits in the output register while the next beat is taken
// reset (rst_n low, synchronous): sums clear, norm factor 1.0, registers to reset values
`include "xray_amplitude_restraint_energy_core_assert.svh"
module xray_amplitude_restraint_energy_core
  import xare_pkg::*;
#(
  parameter int AMP_FRAC_BITS = AMP_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // fobs, sigma, fcalc_inst, fcalc_avg, phase_in, inv_resol_sq
  input  logic [175:0]         in_tdata,
  // req_type
  input  logic                 in_tuser,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // diff_amplitude, phase_out, energy
  output logic [127:0]         out_tdata,
  // in_range
  output logic                 out_tuser,
  output logic                 out_tlast
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  xare_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  xare_dp #(
    .AMP_FRAC_BITS (AMP_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `XARE_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready)
  `XARE_ASSERT_SAME(a_energy_on_last, out_tvalid && !out_tlast, out_tdata[127:64] == '0)
  `XARE_ASSERT_SAME(a_unused_is_zero, out_tvalid && !out_tuser, out_tdata[63:0] == '0)

endmodule
